FILE: rtl/core/sawfc_pkg.sv
package sawfc_pkg;

   // Default frame geometry
   localparam int KIND_OFFSET_DEF     = 15;
   localparam int MAX_FRAME_BYTES_DEF = 1518;

   // Kind byte codes seen on the link
   localparam logic [7:0] KIND_BYTE_DATA = 8'd2;
   localparam logic [7:0] KIND_BYTE_EOT  = 8'd4;
   localparam logic [7:0] KIND_BYTE_ENQ  = 8'd5;

   // Reply codes
   localparam logic REPLY_ACK  = 1'b0;
   localparam logic REPLY_NACK = 1'b1;

   // Frame kind codes on the result channel
   localparam logic [1:0] FK_ENQ  = 2'd0;
   localparam logic [1:0] FK_DATA = 2'd1;
   localparam logic [1:0] FK_EOT  = 2'd2;

   // Check values that are replaced, and their substitute
   localparam logic [7:0] CHECK_ALL_ZERO = 8'd0;
   localparam logic [7:0] CHECK_ALL_ONE  = 8'd255;
   localparam logic [7:0] CHECK_SUBST    = 8'd1;

   typedef struct packed {
      logic       reply_code;
      logic [7:0] reply_seq;
      logic [1:0] frame_kind;
      logic [7:0] computed_check;
      logic       session_over;
   } result_type;

   // Replace a check of all zeros or all ones by one
   function automatic logic [7:0] finish_check(input logic [7:0] x);
      logic [7:0] r;
      r = x;
      if (x == CHECK_ALL_ZERO || x == CHECK_ALL_ONE) begin
         r = CHECK_SUBST;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/sawfc_input_reg.sv
module sawfc_input_reg
   import sawfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_end,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte,
   output logic       held_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       accept;

   // Stall only while a held byte cannot move on
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload of each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
         last_ff <= req_frame_end;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_last  = last_ff;

endmodule

FILE: rtl/core/sawfc_frame_track.sv
module sawfc_frame_track
   import sawfc_pkg::*;
#(
   parameter int KIND_OFFSET     = KIND_OFFSET_DEF,
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] rx_byte,
   input  logic       last,
   output logic       result_valid,
   output result_type result
);

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int SUM_W = ((POS_W > 9) ? POS_W : 9) + 1;
   localparam logic [POS_W-1:0] POS_KIND = POS_W'(KIND_OFFSET);
   localparam logic [POS_W-1:0] POS_SEQ  = POS_W'(KIND_OFFSET + 1);
   localparam logic [POS_W-1:0] POS_LEN  = POS_W'(KIND_OFFSET + 2);
   localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_FRAME_BYTES);
   localparam logic [SUM_W-1:0] DATA_START = SUM_W'(KIND_OFFSET + 3);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       kind_ff, kind_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       check_ff, check_in;
   logic             seen_ff, seen_in;

   logic [POS_W-1:0] pos_nx;
   logic [7:0]       kind_nx, seq_nx, len_nx, xor_nx, check_nx;
   logic             seen_nx;
   logic [SUM_W-1:0] pos_wide;
   logic [SUM_W-1:0] data_end;
   logic [7:0]       check_val;

   assign pos_wide = SUM_W'(pos_ff);
   assign data_end = DATA_START + SUM_W'(len_ff);

   // Fold one byte into the frame state
   always_comb begin
      pos_nx   = pos_ff;
      kind_nx  = kind_ff;
      seq_nx   = seq_ff;
      len_nx   = len_ff;
      xor_nx   = xor_ff;
      check_nx = check_ff;
      seen_nx  = seen_ff;
      if (pos_ff < POS_MAX) begin
         pos_nx = pos_ff + POS_W'(1);
         if (pos_ff == POS_KIND) begin
            kind_nx = rx_byte;
         end else if (pos_ff == POS_SEQ) begin
            seq_nx = rx_byte;
         end else if (pos_ff == POS_LEN) begin
            len_nx = rx_byte;
         end else if (pos_wide >= DATA_START && !seen_ff) begin
            if (pos_wide < data_end) begin
               xor_nx = xor_ff ^ rx_byte;
            end else if (pos_wide == data_end) begin
               check_nx = rx_byte;
               seen_nx  = 1'b1;
            end
         end
      end
   end

   // Build the reply from the state after this byte
   assign check_val = finish_check(xor_nx);

   always_comb begin
      result_valid          = 1'b0;
      result.reply_code     = REPLY_ACK;
      result.reply_seq      = 8'd0;
      result.frame_kind     = FK_ENQ;
      result.computed_check = 8'd0;
      result.session_over   = 1'b0;
      if (last) begin
         if (kind_nx == KIND_BYTE_DATA && seen_nx) begin
            result_valid          = 1'b1;
            result.reply_code     = (check_val != check_nx) ? REPLY_NACK : REPLY_ACK;
            result.reply_seq      = seq_nx;
            result.frame_kind     = FK_DATA;
            result.computed_check = check_val;
         end else if (kind_nx == KIND_BYTE_ENQ) begin
            result_valid = 1'b1;
         end else if (kind_nx == KIND_BYTE_EOT) begin
            result_valid        = 1'b1;
            result.frame_kind   = FK_EOT;
            result.session_over = 1'b1;
         end
      end
   end

   // Advance on each byte, clear at frame end
   always_comb begin
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      xor_in   = xor_ff;
      check_in = check_ff;
      seen_in  = seen_ff;
      if (take) begin
         if (last) begin
            pos_in   = '0;
            kind_in  = 8'd0;
            seq_in   = 8'd0;
            len_in   = 8'd0;
            xor_in   = 8'd0;
            check_in = 8'd0;
            seen_in  = 1'b0;
         end else begin
            pos_in   = pos_nx;
            kind_in  = kind_nx;
            seq_in   = seq_nx;
            len_in   = len_nx;
            xor_in   = xor_nx;
            check_in = check_nx;
            seen_in  = seen_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         kind_ff  <= 8'd0;
         seq_ff   <= 8'd0;
         len_ff   <= 8'd0;
         xor_ff   <= 8'd0;
         check_ff <= 8'd0;
         seen_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         kind_ff  <= kind_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         xor_ff   <= xor_in;
         check_ff <= check_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

FILE: rtl/core/sawfc_result_reg.sv
module sawfc_result_reg
   import sawfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       slot_free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // The slot frees when empty or when its transfer completes now
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the reply until taken
   always_ff @(posedge clock) begin
      if (slot_free && load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/core/stop_and_wait_frame_checker.sv
// Channel    Direction  Handshake             Payload
// req        in         req_valid/req_stall   req_rx_byte, req_frame_end
// rsp        out        rsp_valid/rsp_stall   rsp_reply_code, rsp_reply_seq,
//                                             rsp_frame_kind, rsp_computed_check,
//                                             rsp_session_over
//
// One byte per cycle unless stalled; the reply to the last byte of a frame
// is built as it leaves the input register and is held in the result register.
// Reset is synchronous and clears the frame state and both valid flags.
// A stalled reply holds its register; the input stalls only while a held
// byte cannot pass into a full, stalled result register.
module stop_and_wait_frame_checker
   import sawfc_pkg::*;
#(
   parameter int KIND_OFFSET     = KIND_OFFSET_DEF,
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_reply_code,
   output logic [7:0] rsp_reply_seq,
   output logic [1:0] rsp_frame_kind,
   output logic [7:0] rsp_computed_check,
   output logic       rsp_session_over
);

   logic       held_valid;
   logic [7:0] held_byte;
   logic       held_last;
   logic       slot_free;
   logic       advance;
   logic       result_valid;
   result_type result;
   result_type rsp_data;

   // Move the held byte on whenever the result slot can take it
   assign advance = held_valid && slot_free;

   sawfc_input_reg u_input_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .req_frame_end (req_frame_end),
      .advance       (advance),
      .held_valid    (held_valid),
      .held_byte     (held_byte),
      .held_last     (held_last)
   );

   sawfc_frame_track #(
      .KIND_OFFSET     (KIND_OFFSET),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_frame_track (
      .clock        (clock),
      .reset        (reset),
      .take         (advance),
      .rx_byte      (held_byte),
      .last         (held_last),
      .result_valid (result_valid),
      .result       (result)
   );

   sawfc_result_reg u_result_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && result_valid),
      .load_data (result),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_reply_code     = rsp_data.reply_code;
   assign rsp_reply_seq      = rsp_data.reply_seq;
   assign rsp_frame_kind     = rsp_data.frame_kind;
   assign rsp_computed_check = rsp_data.computed_check;
   assign rsp_session_over   = rsp_data.session_over;

   // A new reply only follows a byte passing into the result slot
   a_reply_after_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("reply appeared without an advancing byte");

   // A byte that does not end a frame leaves the result slot empty
   a_no_reply_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (advance && !held_last) |=> !rsp_valid)
      else $error("reply produced for a byte inside a frame");

   // Session end is flagged for end-of-transmission replies alone
   a_session_over_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_session_over == (rsp_frame_kind == FK_EOT)))
      else $error("session end flag disagrees with frame kind");

   // Input stalls only with a byte held that cannot advance
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (held_valid && rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule
